/* rtl/fcr_pkg.sv */
// fcr_pkg: shared types, character codes and helpers for the framed command receiver.
// No dependencies; imported by every module of the receiver and by its checker.
`timescale 1ns / 1ps

package fcr_pkg;

  // Field widths fixed by the byte-level protocol
  localparam int unsigned CNT_W      = 7;   // frame byte counter
  localparam int unsigned SUM_W      = 12;  // additive checksum, modulo 4096
  localparam int unsigned POS_W      = 7;   // counter-mode position
  localparam int unsigned ADDR_W     = 3;   // motor address register
  localparam int unsigned TMO_W      = 9;   // timeout in ms
  localparam int unsigned HEAD_DEPTH = 11;  // leading frame bytes kept for decoding
  localparam int unsigned HEAD_IDX_W = $clog2(HEAD_DEPTH);
  localparam int unsigned N_MOTORS   = 4;
  localparam int unsigned MOTOR_IDX_W = $clog2(N_MOTORS);
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = ADDR_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_MODE  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [ADDR_W-1:0] MOTOR_ADDRESS_RST = 3'd1;

  // Character codes
  localparam logic [7:0] CHAR_HASH = 8'h23;  // '#', frame start
  localparam logic [7:0] CHAR_CR   = 8'h0D;  // '\r', frame end
  localparam logic [7:0] CHAR_EQ   = 8'h3D;  // '=', offset of six-bit characters
  localparam logic [7:0] CHAR_R    = 8'h52;  // 'R', reset command
  localparam logic [7:0] CHAR_T    = 8'h74;  // 't', motor setpoint command
  localparam logic [7:0] SYNC_BYTE = 8'hF5;  // counter-mode sync

  // Frame positions and thresholds
  localparam logic [HEAD_IDX_W-1:0] CMD_POS   = 4'd2;
  localparam logic [HEAD_IDX_W-1:0] GROUP0_POS = 4'd3;
  localparam logic [HEAD_IDX_W-1:0] GROUP1_POS = 4'd7;
  localparam logic [CNT_W-1:0] DECODE3_MIN = 7'd9;
  localparam logic [CNT_W-1:0] DECODE4_MIN = 7'd13;

  localparam logic [POS_W-1:0] POS_PARK = 7'd100;

  localparam logic [TMO_W-1:0] TIMEOUT_FRAMED  = 9'd500;
  localparam logic [TMO_W-1:0] TIMEOUT_COUNTER = 9'd200;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_pending;
  } fcr_in_t;

  typedef struct packed {
    logic             frame_ok;
    logic             echo_valid;
    logic [7:0]       echo_byte;
    logic             reset_request;
    logic             setpoint_valid;
    logic [7:0]       setpoint;
    logic [TMO_W-1:0] timeout_ms;
  } fcr_out_t;

  // Four '='-offset characters give three bytes, packed {x, y, z}.
  function automatic logic [23:0] decode_group(input logic [7:0] c0, input logic [7:0] c1,
                                               input logic [7:0] c2, input logic [7:0] c3);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] z;
    a = c0 - CHAR_EQ;
    b = c1 - CHAR_EQ;
    c = c2 - CHAR_EQ;
    d = c3 - CHAR_EQ;
    x = {a[5:0], 2'b00} | {4'b0000, b[7:4]};
    y = {b[3:0], 4'b0000} | {2'b00, c[7:2]};
    z = {c[1:0], 6'b000000} | d;
    return {x, y, z};
  endfunction

endpackage

/* rtl/framed_command_receiver_core.sv */
// framed_command_receiver_core: top level of the serial command receiver.
// Instantiates fcr_frame and fcr_count; uses fcr_pkg.
//
//   channel  | ports                            | moves
//   ---------+----------------------------------+--------------------------------
//   input    | in_valid, in_ready, in_data      | one received byte + pending flag
//   result   | out_valid, out_ready, out_data   | one result per received byte
//   config   | cfg_we, cfg_index, cfg_wdata     | register write, no wait
//
// Cycles: one byte per clock sustained while results are taken; a byte is held in the input
// register, processed by the protocol logic as it leaves that register, and its result is
// loaded into the output register, which drives out_valid.
// Reset (rst_n low, synchronous) empties both registers and returns the protocol state to
// idle, the position counter to 100 and the motor values to zero.
// Stalls: a held result stalls the input register; in_ready falls only once that register
// is full as well, and stays high while either register can move.
`timescale 1ns / 1ps

module framed_command_receiver_core
  import fcr_pkg::*;
#(
  parameter int unsigned FRAME_LIMIT = 100
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fcr_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fcr_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [ADDR_W-1:0] motor_address_r;
  logic              counter_mode_r;

  // Input register
  logic    s1_valid_r;
  fcr_in_t s1_data_r;
  logic    s1_adv;

  // Output register
  logic     out_valid_r;
  fcr_out_t out_data_r;

  fcr_out_t frm_res, cnt_res, res_nxt;

  // Advance the input register when the output register is empty or being drained.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Each protocol keeps its own state; only the selected one advances.
  fcr_frame #(
    .FRAME_LIMIT (FRAME_LIMIT)
  ) u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (s1_adv && !counter_mode_r),
    .item          (s1_data_r),
    .motor_address (motor_address_r),
    .res           (frm_res)
  );

  fcr_count u_count (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (s1_adv && counter_mode_r),
    .item          (s1_data_r),
    .motor_address (motor_address_r),
    .res           (cnt_res)
  );

  assign res_nxt = counter_mode_r ? cnt_res : frm_res;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_address_r <= MOTOR_ADDRESS_RST;
      counter_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MOTOR_ADDRESS: motor_address_r <= cfg_wdata;
        REG_COUNTER_MODE:  counter_mode_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register: load on every accepted transaction, drop once passed on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // Output register: hold a result until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

/* rtl/fcr_frame.sv */
// fcr_frame: framed protocol receiver ('#' address command data check '\r').
// Holds phase, byte count, checksum, leading bytes and motor values; uses fcr_pkg.
`timescale 1ns / 1ps

module fcr_frame
  import fcr_pkg::*;
#(
  parameter int unsigned FRAME_LIMIT = 100
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  fcr_in_t           item,
  input  logic [ADDR_W-1:0] motor_address,
  output fcr_out_t          res
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_START   = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  phase_t            phase_r, phase_nxt, phase_eff;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_base;
  logic [SUM_W-1:0]  sum_r, sum_nxt, sum_base, sum_chk;
  logic [7:0]        last0_r, last0_nxt, last1_r, last1_nxt;
  logic [7:0]        head_r [HEAD_DEPTH];
  logic              head_we;
  logic [HEAD_IDX_W-1:0] head_idx;
  logic [7:0]        mv_r   [N_MOTORS];
  logic [7:0]        mv_nxt [N_MOTORS];
  logic              do_store;
  logic              sum_ok;
  logic [23:0]       grp0, grp1;
  logic [7:0]        cmd;
  logic [MOTOR_IDX_W-1:0] motor_idx;

  assign cmd       = head_r[CMD_POS];
  assign grp0      = decode_group(head_r[GROUP0_POS],
                                  head_r[GROUP0_POS + HEAD_IDX_W'(1)],
                                  head_r[GROUP0_POS + HEAD_IDX_W'(2)],
                                  head_r[GROUP0_POS + HEAD_IDX_W'(3)]);
  assign grp1      = decode_group(head_r[GROUP1_POS],
                                  head_r[GROUP1_POS + HEAD_IDX_W'(1)],
                                  head_r[GROUP1_POS + HEAD_IDX_W'(2)],
                                  head_r[GROUP1_POS + HEAD_IDX_W'(3)]);
  assign motor_idx = MOTOR_IDX_W'(motor_address - ADDR_W'(1));
  assign sum_chk   = sum_r - {4'b0000, last0_r} - {4'b0000, last1_r};
  assign sum_ok    = (CHAR_EQ + {2'b00, sum_chk[11:6]}) == last0_r &&
                     (CHAR_EQ + {2'b00, sum_chk[5:0]})  == last1_r;

  always_comb begin
    phase_eff = (cnt_r >= CNT_W'(FRAME_LIMIT)) ? PH_IDLE : phase_r;
    phase_nxt = phase_eff;
    do_store  = 1'b0;
    cnt_base  = cnt_r;
    sum_base  = sum_r;
    mv_nxt    = mv_r;
    res       = '0;

    if (item.rx_byte == CHAR_CR && phase_eff == PH_COLLECT) begin
      phase_nxt = PH_IDLE;
      if (sum_ok) begin
        res.frame_ok      = 1'b1;
        res.echo_valid    = 1'b1;
        res.echo_byte     = cmd;
        res.reset_request = (cmd == CHAR_R);
        if (cmd == CHAR_T) begin
          if (cnt_r >= DECODE3_MIN) begin
            mv_nxt[0] = grp0[23:16];
            mv_nxt[1] = grp0[15:8];
            mv_nxt[2] = grp0[7:0];
            if (cnt_r >= DECODE4_MIN) begin
              mv_nxt[3] = grp1[23:16];
            end
          end
          res.setpoint_valid = 1'b1;
          res.setpoint       = mv_nxt[motor_idx];
          res.timeout_ms     = TIMEOUT_FRAMED;
        end
      end
    end else begin
      unique case (phase_eff)
        PH_IDLE: begin
          // start a fresh frame buffer on every byte seen while idle
          phase_nxt = (item.rx_byte == CHAR_HASH && !item.frame_pending) ? PH_START : PH_IDLE;
          do_store  = 1'b1;
          cnt_base  = '0;
          sum_base  = '0;
        end
        PH_START: begin
          phase_nxt = PH_COLLECT;
          do_store  = 1'b1;
        end
        PH_COLLECT: begin
          do_store  = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    head_we   = do_store && (cnt_base < CNT_W'(HEAD_DEPTH));
    head_idx  = cnt_base[HEAD_IDX_W-1:0];
    cnt_nxt   = do_store ? cnt_base + CNT_W'(1) : cnt_r;
    sum_nxt   = do_store ? sum_base + {4'b0000, item.rx_byte} : sum_r;
    last0_nxt = do_store ? last1_r : last0_r;
    last1_nxt = do_store ? item.rx_byte : last1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      sum_r   <= '0;
      last0_r <= '0;
      last1_r <= '0;
      for (int i = 0; i < N_MOTORS; i++) begin
        mv_r[i] <= '0;
      end
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      last0_r <= last0_nxt;
      last1_r <= last1_nxt;
      mv_r    <= mv_nxt;
    end
  end

  // leading bytes: written only, never cleared
  always_ff @(posedge clk) begin
    if (step && head_we) begin
      head_r[head_idx] <= item.rx_byte;
    end
  end

endmodule

/* rtl/fcr_count.sv */
// fcr_count: sync byte position counter protocol.
// Holds the position counter; uses fcr_pkg.
`timescale 1ns / 1ps

module fcr_count
  import fcr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  fcr_in_t           item,
  input  logic [ADDR_W-1:0] motor_address,
  output fcr_out_t          res
);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc;

  assign pos_inc = pos_r + POS_W'(1);

  always_comb begin
    res     = '0;
    pos_nxt = pos_inc;
    if (item.rx_byte == SYNC_BYTE) begin
      pos_nxt = '0;
    end else if (pos_inc == {{(POS_W-ADDR_W){1'b0}}, motor_address}) begin
      res.setpoint_valid = 1'b1;
      res.setpoint       = item.rx_byte;
      res.timeout_ms     = TIMEOUT_COUNTER;
    end else if (pos_inc > POS_PARK) begin
      pos_nxt = POS_PARK;  // park until the next sync
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_PARK;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

/* rtl/fcr_checker.sv */
// fcr_checker: port-level assertions for framed_command_receiver_core, bound to it.
// Depends on fcr_pkg and on the top level's port list.
`timescale 1ns / 1ps

module fcr_checker
  import fcr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input fcr_out_t out_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  // Echo and reset request only come with a good frame.
  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.echo_valid == out_data.frame_ok &&
                  (!out_data.reset_request ||
                   (out_data.frame_ok && out_data.echo_byte == CHAR_R)) &&
                  (out_data.frame_ok || out_data.echo_byte == 8'h00))
    else $error("echo fields inconsistent with frame_ok");

  // Timeout goes with the setpoint and nothing else.
  a_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.setpoint_valid &&
                   (out_data.timeout_ms == TIMEOUT_FRAMED ||
                    out_data.timeout_ms == TIMEOUT_COUNTER)) ||
                  (!out_data.setpoint_valid && out_data.timeout_ms == '0 &&
                   out_data.setpoint == 8'h00))
    else $error("timeout inconsistent with setpoint_valid");

  // A framed setpoint is always part of a good frame.
  a_framed_sp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.timeout_ms == TIMEOUT_FRAMED |->
      out_data.frame_ok && out_data.echo_byte == CHAR_T)
    else $error("framed setpoint without a good 't' frame");

endmodule

bind framed_command_receiver_core fcr_checker u_fcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
